// ===== sv/hfl_pkg.sv =====
package hfl_pkg;

    // font geometry
    localparam int MAX_HEIGHT   = 16;
    localparam int CODE_DIGITS  = 4;
    localparam int BITMAP_START = 5;
    localparam int STORE_DEPTH  = 4 * MAX_HEIGHT;
    localparam int COUNT_MAX    = STORE_DEPTH + BITMAP_START;
    localparam int ROW_LIMIT    = 16;

    // widths
    localparam int CHAR_W  = 8;
    localparam int NIB_W   = 4;
    localparam int CODE_W  = 16;
    localparam int ROWI_W  = 4;
    localparam int BITS_W  = 16;
    localparam int SIZE_W  = 5;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int COUNT_W = $clog2(COUNT_MAX + 1);
    localparam int ROWS_W  = $clog2(ROW_LIMIT + 1);
    localparam int FIELD_W = CODE_W + ROWI_W + BITS_W + SIZE_W + SIZE_W + 1;
    localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

    localparam logic ITEM_ROW = 1'b0;
    localparam logic ITEM_END = 1'b1;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_ROWS,
        ST_PUSH,
        ST_END
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic latch_geom;
        logic clear_line;
        logic rd_issue;
        logic load_row;
        logic load_end;
    } dp_cmd_t;

    typedef struct packed {
        logic newline;
        logic phase_body;
        logic rows_zero;
        logic nib_last;
        logic row_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/hfl_ram.sv =====
module hfl_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/hfl_datapath.sv =====
module hfl_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hfl_pkg::CHAR_W-1:0]    char_in,
    input  hfl_pkg::dp_cmd_t              cmd,
    output hfl_pkg::dp_status_t           status,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [hfl_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    import hfl_pkg::*;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_BODY,
        PH_SKIP
    } line_phase_t;

    function automatic logic [NIB_W:0] nibble_of(input logic [CHAR_W-1:0] c);
        logic [NIB_W:0] v;
        v = {1'b1, {NIB_W{1'b0}}};
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, c[NIB_W-1:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            v = {1'b0, NIB_W'(c[2:0]) + NIB_W'(9)};
        end
        return v;
    endfunction

    // line state
    line_phase_t          phase_reg, phase_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   bad_reg, bad_next;

    // geometry latched at newline
    logic                 narrow_reg;
    logic [SIZE_W-1:0]    height_reg;
    logic [SIZE_W-1:0]    width_reg;
    logic [ROWS_W-1:0]    rows_reg;

    // row readout
    logic [ROWS_W-1:0]    row_reg;
    logic [1:0]           nib_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic                 pend_reg;
    logic [BITS_W-1:0]    bits_reg;

    // output word
    logic                 out_valid_reg;
    logic [CODE_W-1:0]    o_code_reg;
    logic                 o_kind_reg;
    logic [ROWI_W-1:0]    o_row_reg;
    logic [BITS_W-1:0]    o_bits_reg;
    logic [SIZE_W-1:0]    o_width_reg;
    logic [SIZE_W-1:0]    o_height_reg;
    logic                 o_setsz_reg;
    logic                 o_last_reg;

    logic [NIB_W:0]       nib_v;
    logic                 is_hex;
    logic                 newline;
    logic [COUNT_W-1:0]   store_pos;
    logic [COUNT_W-1:0]   len;
    logic [COUNT_W-1:0]   good;
    logic [COUNT_W-1:0]   rows_full;
    logic [COUNT_W-1:0]   height_full;
    logic                 narrow;
    logic [SIZE_W-1:0]    height_w;
    logic [SIZE_W-1:0]    width_w;
    logic                 ram_we;
    logic [NIB_W-1:0]     rdata;
    logic [BITS_W-1:0]    row_word;

    assign nib_v     = nibble_of(char_in);
    assign is_hex    = ~nib_v[NIB_W];
    assign newline   = (char_in == CHAR_NEWLINE);
    assign store_pos = count_reg - COUNT_W'(BITMAP_START);

    // geometry from the finished line
    assign len         = (count_reg > COUNT_W'(BITMAP_START)) ? store_pos : '0;
    assign narrow      = (len >> 1) <= COUNT_W'(MAX_HEIGHT);
    assign good        = (len < bad_reg) ? len : bad_reg;
    assign rows_full   = narrow ? (good >> 1) : (good >> 2);
    assign height_full = narrow ? (len >> 1) : (len >> 2);
    assign height_w    = height_full[SIZE_W-1:0];
    assign width_w     = narrow ? (height_w >> 1) : height_w;

    assign ram_we = cmd.accept && !newline && (phase_reg == PH_BODY)
                    && (count_reg >= COUNT_W'(BITMAP_START))
                    && (count_reg < COUNT_W'(COUNT_MAX));

    hfl_ram #(
        .WIDTH (NIB_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (store_pos[ADDR_W-1:0]),
        .wdata (nib_v[NIB_W-1:0]),
        .re    (cmd.rd_issue),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // narrow rows sit in the upper byte
    assign row_word = narrow_reg ? {bits_reg[NIB_W-1:0], rdata, 8'h00}
                                 : {bits_reg[BITS_W-NIB_W-1:0], rdata};

    // line accumulation
    always_comb
    begin
        phase_next = phase_reg;
        code_next  = code_reg;
        count_next = count_reg;
        bad_next   = bad_reg;
        if (cmd.clear_line || cmd.load_end)
        begin
            phase_next = PH_CODE;
            code_next  = '0;
            count_next = '0;
            bad_next   = COUNT_W'(STORE_DEPTH);
        end
        else if (cmd.accept && !newline)
        begin
            if (phase_reg == PH_CODE)
            begin
                if (!is_hex)
                begin
                    phase_next = PH_SKIP;
                end
                else
                begin
                    code_next = {code_reg[CODE_W-NIB_W-1:0], nib_v[NIB_W-1:0]};
                    if (count_reg == COUNT_W'(CODE_DIGITS - 1))
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            if (ram_we && !is_hex && (bad_reg >= COUNT_W'(STORE_DEPTH)))
            begin
                bad_next = store_pos;
            end
            if (count_reg < COUNT_W'(COUNT_MAX))
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CODE;
            code_reg      <= '0;
            count_reg     <= '0;
            bad_reg       <= COUNT_W'(STORE_DEPTH);
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
            count_reg <= count_next;
            bad_reg   <= bad_next;
            pend_reg  <= cmd.rd_issue;
            if (cmd.load_row || cmd.load_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // readout sequencing and output word
    always_ff @(posedge clk)
    begin
        if (cmd.latch_geom)
        begin
            narrow_reg <= narrow;
            height_reg <= height_w;
            width_reg  <= width_w;
            rows_reg   <= rows_full[ROWS_W-1:0];
            row_reg    <= '0;
            nib_reg    <= '0;
            addr_reg   <= '0;
        end
        if (cmd.rd_issue)
        begin
            addr_reg <= addr_reg + ADDR_W'(1);
            nib_reg  <= status.nib_last ? 2'd0 : nib_reg + 2'd1;
            if (pend_reg)
            begin
                bits_reg <= {bits_reg[BITS_W-NIB_W-1:0], rdata};
            end
        end
        if (cmd.load_row)
        begin
            row_reg      <= row_reg + ROWS_W'(1);
            o_code_reg   <= code_reg;
            o_kind_reg   <= ITEM_ROW;
            o_row_reg    <= row_reg[ROWI_W-1:0];
            o_bits_reg   <= row_word;
            o_width_reg  <= '0;
            o_height_reg <= '0;
            o_setsz_reg  <= 1'b0;
            o_last_reg   <= 1'b0;
        end
        else if (cmd.load_end)
        begin
            o_code_reg   <= code_reg;
            o_kind_reg   <= ITEM_END;
            o_row_reg    <= '0;
            o_bits_reg   <= '0;
            o_width_reg  <= width_reg;
            o_height_reg <= height_reg;
            o_setsz_reg  <= narrow_reg;
            o_last_reg   <= 1'b1;
        end
    end

    assign status.newline    = newline;
    assign status.phase_body = (phase_reg == PH_BODY);
    assign status.rows_zero  = (rows_full == '0);
    assign status.nib_last   = (nib_reg == (narrow_reg ? 2'd1 : 2'd3));
    assign status.row_last   = ((row_reg + ROWS_W'(1)) == rows_reg);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = TDATA_W'({o_setsz_reg, o_height_reg, o_width_reg,
                                o_bits_reg, o_row_reg, o_code_reg});

endmodule

// ===== sv/hfl_ctrl.sv =====
module hfl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  hfl_pkg::dp_status_t  status,
    output hfl_pkg::dp_cmd_t     cmd
);

    import hfl_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RECV:
            begin
                if (s_tvalid && status.newline && status.phase_body)
                begin
                    state_next = status.rows_zero ? ST_END : ST_ROWS;
                end
            end
            ST_ROWS:
            begin
                if (status.nib_last)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (status.out_free)
                begin
                    state_next = status.row_last ? ST_END : ST_ROWS;
                end
            end
            ST_END:
            begin
                if (status.out_free)
                begin
                    state_next = ST_RECV;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_RECV:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.newline)
                begin
                    cmd.latch_geom = status.phase_body;
                    cmd.clear_line = !status.phase_body;
                end
            end
            ST_ROWS:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_PUSH:
            begin
                cmd.load_row = status.out_free;
            end
            ST_END:
            begin
                cmd.load_end = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/hex_font_line_parser.sv =====
// hex font line parser
//
// input stream: one text byte per word on s_tdata; byte 0x0a ends a line. a
// line is four hex code digits, one separator byte, then bitmap hex digits.
// output stream: at each newline of a line with a good code, one word per
// complete bitmap row (m_tuser = 0), then one glyph-end word (m_tuser = 1,
// m_tlast = 1) with width, height and the narrow-glyph font-size flag. lines
// whose code is bad give no words.
//
// text bytes are taken one per cycle while no readout runs. a newline starts
// the row readout from the digit store, one nibble read per cycle within a
// row: each row reads its digits (2 for narrow, 4 for wide rows) and then
// loads its row word into the output register, and the glyph-end word
// follows the last row. s_tready is low during readout.
//
// reset (rst_n low, asynchronous) drops any partial line and any word held
// at the output. a stalled receiver holds the output word; readout waits for
// it, and text bytes keep flowing while only the glyph-end word is pending.
module hex_font_line_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hfl_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] char_in
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] glyph_code, [19:16] row_index, [35:20] row_bits,
    // [40:36] pixel_width, [45:41] font_height, [46] set_font_size, [47] zero
    output logic [hfl_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tuser,   // [0] item_kind
    output logic                          m_tlast    // last word of the line
);

    import hfl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: byte intake, row readout, glyph end
    hfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // line state, digit store, row assembly and output register
    hfl_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
